// ===== rtl/core/mrm_pkg.sv =====
package mrm_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_OPEN  = 2'd2,
    FUNC_CLOSE = 2'd3
  } func_t;

  localparam int unsigned REG_VOLUME = 0;
  localparam int unsigned REG_STEP0  = 1;
  localparam int unsigned REG_STEP3  = 4;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          channel;
    logic signed [15:0]  sample_left;
    logic signed [15:0]  sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic               status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SNAP,
    ST_CHAN,
    ST_RD1,
    ST_INTERP,
    ST_ACC,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/multichannel_resampling_audio_mixer.sv =====
// Channel   | Handshake            | Transfer when
// input     | push / full          | push && !full
// result    | empty / pop          | pop && !empty
// config    | cfg_valid / cfg_ready| cfg_valid && cfg_ready
//
// Write, open and close go from IDLE to OUT; a tick runs SNAP, then CHAN, RD1, INTERP
// and ACC per channel (two reads on the single ring read port), then FINISH and OUT.
// Reset clears pointers, phases, held samples and flags; ring contents stay undefined.
// Input is buffered two deep and the result one deep, so either side may stall.
module multichannel_resampling_audio_mixer #(
  parameter int unsigned CHANNELS     = 4,
  parameter int unsigned RING_FRAMES  = 2048,
  parameter int unsigned CHUNK_FRAMES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mrm_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output mrm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  logic [4:0] volume_shift;
  logic [CHANNELS*20-1:0] steps;
  logic avail, take, rv, rr;
  mrm_pkg::in_item_t  qi;
  mrm_pkg::out_item_t ro;

  assign cfg_ready = 1'b1;

  // hold the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_shift <= '0;
      for (int i = 0; i < CHANNELS; i++) steps[i*20 +: 20] <= 20'd65536;
    end else if (cfg_valid) begin
      if (cfg_index == 3'(mrm_pkg::REG_VOLUME)) volume_shift <= cfg_data[4:0];
      for (int i = 0; i < CHANNELS; i++)
        if ({29'd0, cfg_index} == mrm_pkg::REG_STEP0 + i && cfg_index <= 3'(mrm_pkg::REG_STEP3))
          steps[i*20 +: 20] <= cfg_data;
    end
  end

  mrm_front u_front (
    .clk, .rst, .push, .full, .din(in_item), .take, .avail, .dout(qi)
  );

  mrm_engine #(
    .CHANNELS(CHANNELS), .RING_FRAMES(RING_FRAMES), .CHUNK_FRAMES(CHUNK_FRAMES)
  ) u_engine (
    .clk, .rst, .avail, .item(qi), .take, .volume_shift, .steps,
    .res_valid(rv), .res_ready(rr), .res(ro)
  );

  mrm_out u_out (
    .clk, .rst, .in_valid(rv), .in_ready(rr), .din(ro), .empty, .pop, .dout(out_item)
  );
endmodule

// ===== rtl/core/mrm_front.sv =====
// Input side: a two-entry queue holding accepted items until the engine takes them.
module mrm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mrm_pkg::in_item_t din,
  input  logic              take,
  output logic              avail,
  output mrm_pkg::in_item_t dout
);
  mrm_pkg::in_item_t slot [2];
  logic       rd_idx;
  logic       wr_idx;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign dout    = slot[rd_idx];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_idx] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= 1'b0;
      wr_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_idx <= ~wr_idx;
      if (do_take) rd_idx <= ~rd_idx;
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end
endmodule

// ===== rtl/core/mrm_engine.sv =====
// Back end: writes, opens, closes and the per-channel tick sequence.
module mrm_engine #(
  parameter int unsigned CHANNELS     = 4,
  parameter int unsigned RING_FRAMES  = 2048,
  parameter int unsigned CHUNK_FRAMES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  mrm_pkg::in_item_t  item,
  output logic               take,
  input  logic [4:0]         volume_shift,
  input  logic [CHANNELS*20-1:0] steps,
  output logic               res_valid,
  input  logic               res_ready,
  output mrm_pkg::out_item_t res
);
  localparam int unsigned AW  = $clog2(RING_FRAMES);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MW  = CW + AW;
  localparam int unsigned QW  = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;
  localparam int unsigned PHW = PW + 16;

  logic [31:0] ring [CHANNELS*RING_FRAMES];
  logic [PW-1:0]  rdp   [CHANNELS];
  logic [PW-1:0]  wrp   [CHANNELS];
  logic [PHW-1:0] phase [CHANNELS];
  logic signed [15:0] hl [CHANNELS];
  logic signed [15:0] hr [CHANNELS];
  logic [CHANNELS-1:0] act;
  logic [PW-1:0]  snap  [CHANNELS];
  logic [QW-1:0]  chunk_pos;

  mrm_pkg::state_t state, state_next;
  logic [CW-1:0]  ch;
  logic [CW:0]    ch_cnt;
  logic signed [19:0] acc_l, acc_r;
  logic [31:0] w0, rdata;
  logic        rd_en;
  logic [MW-1:0] rd_addr;
  logic        has_next;
  logic signed [16:0] dl, dr;
  logic signed [32:0] pl, pr;
  logic signed [15:0] sl, sr;
  logic        use_held;

  logic [CW-1:0]  ich;
  logic           ich_ok;
  logic [PW-1:0]  used_ich;
  logic           wr_drop;
  logic [PW-1:0]  idx_c;
  logic [AW-1:0]  ra;
  logic signed [19:0] shl, shr;
  logic signed [15:0] ol, orr;

  assign ich    = item.channel[CW-1:0];
  assign ich_ok = ({30'd0, item.channel} < CHANNELS);
  assign used_ich = wrp[ich] - rdp[ich];
  assign wr_drop = (item.func == mrm_pkg::FUNC_WRITE) && ich_ok &&
                   (used_ich >= PW'(RING_FRAMES));
  assign idx_c  = phase[ch][PHW-1:16];

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= ring[rd_addr];
  end

  always_comb begin
    rd_en   = 1'b0;
    ra      = rdp[ch][AW-1:0] + idx_c[AW-1:0];
    rd_addr = {ch, ra};
    if (state == mrm_pkg::ST_CHAN) rd_en = 1'b1;
    if (state == mrm_pkg::ST_RD1) begin
      rd_en   = 1'b1;
      rd_addr = {ch, ra + AW'(1)};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mrm_pkg::ST_IDLE:
        if (avail && item.func == mrm_pkg::FUNC_TICK) state_next = mrm_pkg::ST_SNAP;
        else if (avail) state_next = mrm_pkg::ST_OUT;
      mrm_pkg::ST_SNAP: state_next = mrm_pkg::ST_CHAN;
      mrm_pkg::ST_CHAN: state_next = mrm_pkg::ST_RD1;
      mrm_pkg::ST_RD1: state_next = mrm_pkg::ST_INTERP;
      mrm_pkg::ST_INTERP: state_next = mrm_pkg::ST_ACC;
      mrm_pkg::ST_ACC:
        if (ch_cnt == (CW+1)'(CHANNELS - 1)) state_next = mrm_pkg::ST_FINISH;
        else state_next = mrm_pkg::ST_CHAN;
      mrm_pkg::ST_FINISH: state_next = mrm_pkg::ST_OUT;
      mrm_pkg::ST_OUT: if (res_ready) state_next = mrm_pkg::ST_IDLE;
      default: state_next = mrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take      = (state == mrm_pkg::ST_IDLE) && avail;
    res_valid = (state == mrm_pkg::ST_OUT);
  end

  assign use_held = !act[ch] || snap[ch] == '0 || idx_c >= snap[ch];
  assign has_next = (idx_c + PW'(1)) < snap[ch];
  assign shl = acc_l >>> volume_shift;
  assign shr = acc_r >>> volume_shift;
  assign ol = (shl > 20'sd32767) ? 16'sd32767 : (shl < -20'sd32768) ? -16'sd32768 : shl[15:0];
  assign orr = (shr > 20'sd32767) ? 16'sd32767 : (shr < -20'sd32768) ? -16'sd32768 : shr[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrm_pkg::ST_IDLE;
      act       <= '0;
      chunk_pos <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rdp[i] <= '0; wrp[i] <= '0; phase[i] <= '0;
        hl[i] <= '0; hr[i] <= '0; snap[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        mrm_pkg::ST_IDLE: if (avail) begin
          res <= '{mix_left: '0, mix_right: '0, status: wr_drop};
          ch <= '0;
          ch_cnt <= '0;
          acc_l <= '0;
          acc_r <= '0;
          if (item.func != mrm_pkg::FUNC_TICK && ich_ok) begin
            if (item.func == mrm_pkg::FUNC_WRITE) begin
              if (!wr_drop) begin
                ring[{ich, wrp[ich][AW-1:0]}] <= {item.sample_right, item.sample_left};
                wrp[ich] <= wrp[ich] + PW'(1);
              end
            end else begin
              rdp[ich] <= '0; wrp[ich] <= '0; phase[ich] <= '0; snap[ich] <= '0;
              act[ich] <= (item.func == mrm_pkg::FUNC_OPEN);
              if (item.func == mrm_pkg::FUNC_OPEN) begin
                hl[ich] <= '0; hr[ich] <= '0;
              end
            end
          end
        end
        mrm_pkg::ST_SNAP: begin
          // take the snapshot of available frames at the first tick of a chunk
          if (chunk_pos == '0)
            for (int i = 0; i < CHANNELS; i++)
              snap[i] <= act[i] ? (wrp[i] - rdp[i]) : '0;
        end
        mrm_pkg::ST_CHAN: ;
        mrm_pkg::ST_RD1: w0 <= rdata;
        mrm_pkg::ST_INTERP: begin
          dl <= 17'(signed'(rdata[15:0])) - 17'(signed'(w0[15:0]));
          dr <= 17'(signed'(rdata[31:16])) - 17'(signed'(w0[31:16]));
        end
        mrm_pkg::ST_ACC: begin
          if (act[ch]) begin
            if (use_held) begin
              acc_l <= acc_l + 20'(hl[ch]);
              acc_r <= acc_r + 20'(hr[ch]);
            end else begin
              hl[ch] <= sl; hr[ch] <= sr;
              acc_l <= acc_l + 20'(sl);
              acc_r <= acc_r + 20'(sr);
              phase[ch] <= phase[ch] + PHW'(steps[ch*20 +: 20]);
            end
          end
          ch <= ch + CW'(1);
          ch_cnt <= ch_cnt + (CW+1)'(1);
        end
        mrm_pkg::ST_FINISH: begin
          res.mix_left  <= ol;
          res.mix_right <= orr;
          if (chunk_pos == QW'(CHUNK_FRAMES - 1)) begin
            chunk_pos <= '0;
            for (int i = 0; i < CHANNELS; i++)
              if (snap[i] != '0) begin
                rdp[i] <= rdp[i] + ((phase[i][PHW-1:16] > snap[i]) ? snap[i] : phase[i][PHW-1:16]);
                phase[i] <= {{PW{1'b0}}, phase[i][15:0]};
              end
          end else chunk_pos <= chunk_pos + QW'(1);
        end
        mrm_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // interpolation product, floor shift by 15
  always_comb begin
    pl = dl * $signed({1'b0, phase[ch][15:1]});
    pr = dr * $signed({1'b0, phase[ch][15:1]});
    if (has_next) begin
      sl = 16'(signed'(w0[15:0]) + 17'(pl >>> 15));
      sr = 16'(signed'(w0[31:16]) + 17'(pr >>> 15));
    end else begin
      sl = signed'(w0[15:0]);
      sr = signed'(w0[31:16]);
    end
  end
endmodule

// ===== rtl/core/mrm_out.sv =====
// Result side: one-entry buffer presenting the result as a queue head.
module mrm_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrm_pkg::out_item_t din,
  output logic               empty,
  input  logic               pop,
  output mrm_pkg::out_item_t dout
);
  logic held;
  assign empty    = !held;
  assign in_ready = !held || pop;

  always_ff @(posedge clk) begin
    if (rst) held <= 1'b0;
    else if (in_valid && in_ready) held <= 1'b1;
    else if (pop) held <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) dout <= din;
  end
endmodule
